// ===== src/rtl_pkg.sv =====
package rtl_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_ACK  = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_SCAN = 2'd2;

	localparam logic [2:0] K_NEW     = 3'd0;
	localparam logic [2:0] K_RETX    = 3'd1;
	localparam logic [2:0] K_FULL    = 3'd2;
	localparam logic [2:0] K_STOP    = 3'd3;
	localparam logic [2:0] K_INVALID = 3'd4;
	localparam logic [2:0] K_ACK_OK  = 3'd5;
	localparam logic [2:0] K_ACK_IGN = 3'd6;
	localparam logic [2:0] K_TICK    = 3'd7;

	localparam logic [1:0] REG_RUN     = 2'd0;
	localparam logic [1:0] REG_PEER    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic        RUN_RESET     = 1'b1;
	localparam logic [7:0]  PEER_RESET    = 8'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef struct packed {
		logic        live;
		logic [1:0]  op;
		logic        hit;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [11:0] length;
		logic [31:0] stamp;
	} pkt_t;

	typedef struct packed {
		logic        mark;
		logic        commit;
		logic [31:0] now;
		logic [31:0] base;
		logic [15:0] timeout;
	} bcast_t;

endpackage

// ===== src/retransmit_table_link.sv =====
// channel   | handshake                   | payload
// ----------+-----------------------------+-------------------------------------------
// request   | req_valid / req_stall       | action, src_id, ack_seq, payload_handle,
//           |                             | payload_length
// response  | rsp_valid / rsp_stall       | kind, frame_seq, frame_handle, frame_length,
//           |                             | queue_count, queue_empty, last
// config    | psel, penable, pwrite, ...  | paddr, pwdata, prdata
//
// one request at a time; a packet walks the cell chain one cell a cycle
// send or ack: dispatch, one pass down the cell chain, emit; refused send, foreign ack or stopped tick: dispatch, emit
// tick with R retransmits: dispatch, mark, scan, then R + 1 scan passes down the chain, each ending in an emit
// reset clears valid bits, counters and registers at once; no clearing pass
// a stalled response holds the block after its result, the request side waits
module retransmit_table_link #(
	parameter int QUEUE_DEPTH = rtl_pkg::QUEUE_DEPTH_DEFAULT,
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtl_pkg::ADDR_W-1:0]  paddr,
	input  logic [rtl_pkg::DATA_W-1:0]  pwdata,
	output logic [rtl_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [1:0]                  action,
	input  logic [7:0]                  src_id,
	input  logic [31:0]                 ack_seq,
	input  logic [15:0]                 payload_handle,
	input  logic [11:0]                 payload_length,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [2:0]                  kind,
	output logic [31:0]                 frame_seq,
	output logic [15:0]                 frame_handle,
	output logic [11:0]                 frame_length,
	output logic [CNT_W-1:0]            queue_count,
	output logic                        queue_empty,
	output logic                        last
);

	logic        run_q;
	logic [7:0]  peer_q;
	logic [15:0] tmo_q;
	logic        wr_en;

	rtl_pkg::bcast_t  bc;
	logic [IDX_W-1:0] commit_idx;
	rtl_pkg::pkt_t    pkt_chain [QUEUE_DEPTH+1];
	logic [IDX_W-1:0] idx_chain [QUEUE_DEPTH+1];

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= rtl_pkg::RUN_RESET;
			peer_q <= rtl_pkg::PEER_RESET;
			tmo_q  <= rtl_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				rtl_pkg::REG_RUN:     run_q  <= pwdata[0];
				rtl_pkg::REG_PEER:    peer_q <= pwdata[7:0];
				rtl_pkg::REG_TIMEOUT: tmo_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rtl_pkg::REG_RUN:     prdata = {31'd0, run_q};
			rtl_pkg::REG_PEER:    prdata = {24'd0, peer_q};
			rtl_pkg::REG_TIMEOUT: prdata = {16'd0, tmo_q};
			default:              prdata = '0;
		endcase
	end

	assign idx_chain[0] = '0;

	rtl_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.action         (action),
		.src_id         (src_id),
		.ack_seq        (ack_seq),
		.payload_handle (payload_handle),
		.payload_length (payload_length),
		.link_running   (run_q),
		.peer_id        (peer_q),
		.timeout_ticks  (tmo_q),
		.bc             (bc),
		.commit_idx     (commit_idx),
		.inject         (pkt_chain[0]),
		.chain_pkt      (pkt_chain[QUEUE_DEPTH]),
		.chain_idx      (idx_chain[QUEUE_DEPTH]),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.kind           (kind),
		.frame_seq      (frame_seq),
		.frame_handle   (frame_handle),
		.frame_length   (frame_length),
		.queue_count    (queue_count),
		.queue_empty    (queue_empty),
		.last           (last)
	);

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		rtl_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.CELL_IDX   (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bc         (bc),
			.commit_idx (commit_idx),
			.pkt_in     (pkt_chain[g]),
			.idx_in     (idx_chain[g]),
			.pkt_out    (pkt_chain[g+1]),
			.idx_out    (idx_chain[g+1])
		);
	end

endmodule

// ===== src/rtl_cell.sv =====
module rtl_cell #(
	parameter int QUEUE_DEPTH = rtl_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int CELL_IDX = 0,
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rtl_pkg::bcast_t     bc,
	input  logic [IDX_W-1:0]    commit_idx,
	input  rtl_pkg::pkt_t       pkt_in,
	input  logic [IDX_W-1:0]    idx_in,
	output rtl_pkg::pkt_t       pkt_out,
	output logic [IDX_W-1:0]    idx_out
);

	logic        valid_q;
	logic        pend_q;
	logic [31:0] seq_q;
	logic [15:0] handle_q;
	logic [11:0] length_q;
	logic [31:0] sent_q;
	rtl_pkg::pkt_t    pkt_q;
	logic [IDX_W-1:0] idx_q;

	rtl_pkg::pkt_t    nxt;
	logic [IDX_W-1:0] nidx;
	logic [31:0] own_key;
	logic [31:0] best_key;
	logic        self_commit;
	logic        eligible;
	logic        take_free;
	logic        take_ack;
	logic        take_scan;

	always_comb begin
		own_key     = seq_q - bc.base;
		best_key    = pkt_in.seq - bc.base;
		self_commit = bc.commit && (commit_idx == IDX_W'(CELL_IDX));
		eligible    = pend_q && !self_commit;
		take_free   = pkt_in.live && (pkt_in.op == rtl_pkg::OP_SEND) && !pkt_in.hit && !valid_q;
		take_ack    = pkt_in.live && (pkt_in.op == rtl_pkg::OP_ACK) && !pkt_in.hit
			&& valid_q && (seq_q == pkt_in.seq);
		take_scan   = pkt_in.live && (pkt_in.op == rtl_pkg::OP_SCAN) && eligible
			&& (!pkt_in.hit || (own_key < best_key));
		nxt  = pkt_in;
		nidx = idx_in;
		if (take_free) begin
			nxt.hit = 1'b1;
		end
		if (take_ack) begin
			nxt.hit    = 1'b1;
			nxt.handle = handle_q;
			nxt.length = length_q;
		end
		if (take_scan) begin
			nxt.hit    = 1'b1;
			nxt.seq    = seq_q;
			nxt.handle = handle_q;
			nxt.length = length_q;
			nidx       = IDX_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
			pkt_q   <= '0;
		end else begin
			pkt_q <= nxt;
			if (take_free) begin
				valid_q <= 1'b1;
			end else if (take_ack) begin
				valid_q <= 1'b0;
			end
			if (bc.mark) begin
				pend_q <= valid_q && ((bc.now - sent_q) >= 32'(bc.timeout));
			end else if (self_commit) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= nidx;
		if (take_free) begin
			seq_q    <= pkt_in.seq;
			handle_q <= pkt_in.handle;
			length_q <= pkt_in.length;
			sent_q   <= pkt_in.stamp;
		end else if (self_commit) begin
			sent_q <= bc.now;
		end
	end

	assign pkt_out = pkt_q;
	assign idx_out = idx_q;

endmodule

// ===== src/rtl_ctrl.sv =====
module rtl_ctrl #(
	parameter int QUEUE_DEPTH = rtl_pkg::QUEUE_DEPTH_DEFAULT,
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       action,
	input  logic [7:0]       src_id,
	input  logic [31:0]      ack_seq,
	input  logic [15:0]      payload_handle,
	input  logic [11:0]      payload_length,
	input  logic             link_running,
	input  logic [7:0]       peer_id,
	input  logic [15:0]      timeout_ticks,
	output rtl_pkg::bcast_t  bc,
	output logic [IDX_W-1:0] commit_idx,
	output rtl_pkg::pkt_t    inject,
	input  rtl_pkg::pkt_t    chain_pkt,
	input  logic [IDX_W-1:0] chain_idx,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [2:0]       kind,
	output logic [31:0]      frame_seq,
	output logic [15:0]      frame_handle,
	output logic [11:0]      frame_length,
	output logic [CNT_W-1:0] queue_count,
	output logic             queue_empty,
	output logic             last
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_MARK     = 3'd2;
	localparam logic [2:0] S_WAIT     = 3'd3;
	localparam logic [2:0] S_EMIT     = 3'd4;
	localparam logic [2:0] S_SCAN     = 3'd5;

	logic [2:0]       state_q;
	logic [1:0]       act_q;
	logic [7:0]       src_q;
	logic [31:0]      aseq_q;
	logic [15:0]      hand_q;
	logic [11:0]      len_q;
	logic [31:0]      now_q;
	logic [31:0]      next_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       res_kind_q;
	logic [31:0]      res_seq_q;
	logic [15:0]      res_hand_q;
	logic [11:0]      res_len_q;
	logic             res_last_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             rsp_valid_q;
	logic [2:0]       kind_q;
	logic [31:0]      seq_q;
	logic [15:0]      handle_q;
	logic [11:0]      length_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic             last_q;

	logic accept;
	logic out_free;
	logic emit;
	logic rescan;
	logic send_go;
	logic ack_go;

	assign accept   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit     = (state_q == S_EMIT) && out_free;
	assign rescan   = emit && !res_last_q;
	assign send_go  = (state_q == S_DISPATCH) && (act_q == rtl_pkg::ACT_SEND)
		&& (len_q != 12'd0) && link_running;
	assign ack_go   = (state_q == S_DISPATCH) && (act_q == rtl_pkg::ACT_ACK) && (src_q == peer_id);

	always_comb begin
		inject = '0;
		if (send_go) begin
			inject.live   = 1'b1;
			inject.op     = rtl_pkg::OP_SEND;
			inject.seq    = next_q;
			inject.handle = hand_q;
			inject.length = len_q;
			inject.stamp  = now_q;
		end else if (ack_go) begin
			inject.live = 1'b1;
			inject.op   = rtl_pkg::OP_ACK;
			inject.seq  = aseq_q;
		end else if ((state_q == S_SCAN) || rescan) begin
			inject.live = 1'b1;
			inject.op   = rtl_pkg::OP_SCAN;
		end
		bc.mark    = (state_q == S_MARK);
		bc.commit  = rescan;
		bc.now     = now_q;
		bc.base    = next_q;
		bc.timeout = timeout_ticks;
	end

	assign commit_idx = res_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			next_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (act_q)
						rtl_pkg::ACT_SEND: begin
							if (send_go) begin
								state_q <= S_WAIT;
							end else begin
								state_q <= S_EMIT;
							end
						end
						rtl_pkg::ACT_ACK: begin
							if (ack_go) begin
								state_q <= S_WAIT;
							end else begin
								state_q <= S_EMIT;
							end
						end
						rtl_pkg::ACT_TICK: begin
							now_q <= now_q + 32'd1;
							if (link_running) begin
								state_q <= S_MARK;
							end else begin
								state_q <= S_EMIT;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_MARK: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (chain_pkt.live) begin
						state_q <= S_EMIT;
						if (chain_pkt.op == rtl_pkg::OP_SEND && chain_pkt.hit) begin
							count_q <= count_q + CNT_W'(1);
							next_q  <= next_q + 32'd1;
						end
						if (chain_pkt.op == rtl_pkg::OP_ACK && chain_pkt.hit) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= res_last_q ? S_IDLE : S_WAIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			src_q  <= src_id;
			aseq_q <= ack_seq;
			hand_q <= payload_handle;
			len_q  <= payload_length;
		end
		if (state_q == S_DISPATCH) begin
			res_seq_q  <= 32'd0;
			res_hand_q <= 16'd0;
			res_len_q  <= 12'd0;
			res_last_q <= 1'b1;
			case (act_q)
				rtl_pkg::ACT_SEND: begin
					if (len_q == 12'd0) begin
						res_kind_q <= rtl_pkg::K_INVALID;
					end else begin
						res_kind_q <= rtl_pkg::K_STOP;
					end
				end
				rtl_pkg::ACT_ACK: begin
					res_kind_q <= rtl_pkg::K_ACK_IGN;
					res_seq_q  <= aseq_q;
				end
				default: begin
					res_kind_q <= rtl_pkg::K_TICK;
				end
			endcase
		end
		if (state_q == S_WAIT && chain_pkt.live) begin
			res_idx_q <= chain_idx;
			case (chain_pkt.op)
				rtl_pkg::OP_SEND: begin
					res_last_q <= 1'b1;
					if (chain_pkt.hit) begin
						res_kind_q <= rtl_pkg::K_NEW;
						res_seq_q  <= chain_pkt.seq;
						res_hand_q <= chain_pkt.handle;
						res_len_q  <= chain_pkt.length;
					end else begin
						res_kind_q <= rtl_pkg::K_FULL;
						res_seq_q  <= 32'd0;
						res_hand_q <= 16'd0;
						res_len_q  <= 12'd0;
					end
				end
				rtl_pkg::OP_ACK: begin
					res_last_q <= 1'b1;
					res_seq_q  <= chain_pkt.seq;
					res_hand_q <= chain_pkt.handle;
					res_len_q  <= chain_pkt.length;
					res_kind_q <= chain_pkt.hit ? rtl_pkg::K_ACK_OK : rtl_pkg::K_ACK_IGN;
				end
				default: begin
					if (chain_pkt.hit) begin
						res_kind_q <= rtl_pkg::K_RETX;
						res_seq_q  <= chain_pkt.seq;
						res_hand_q <= chain_pkt.handle;
						res_len_q  <= chain_pkt.length;
						res_last_q <= 1'b0;
					end else begin
						res_kind_q <= rtl_pkg::K_TICK;
						res_seq_q  <= 32'd0;
						res_hand_q <= 16'd0;
						res_len_q  <= 12'd0;
						res_last_q <= 1'b1;
					end
				end
			endcase
		end
		if (emit) begin
			kind_q    <= res_kind_q;
			seq_q     <= res_seq_q;
			handle_q  <= res_hand_q;
			length_q  <= res_len_q;
			cnt_out_q <= count_q;
			last_q    <= res_last_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign kind         = kind_q;
	assign frame_seq    = seq_q;
	assign frame_handle = handle_q;
	assign frame_length = length_q;
	assign queue_count  = cnt_out_q;
	assign queue_empty  = (cnt_out_q == '0);
	assign last         = last_q;

endmodule

// ===== verif/retransmit_table_link_test.sv =====
module retransmit_table_link_test;

	localparam int QDEPTH = rtl_pkg::QUEUE_DEPTH_DEFAULT;
	localparam int QCW = $clog2(QDEPTH + 1);
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 50;
	localparam int PRINT_CAP = 100;

	typedef enum logic {ROW_REQ, ROW_WRITE} row_e;

	typedef struct packed {
		logic [2:0]     kind;
		logic [31:0]    seq;
		logic [15:0]    handle;
		logic [11:0]    length;
		logic [QCW-1:0] count;
		logic           empty;
		logic           last;
	} frame_t;

	typedef struct {
		row_e        what;
		logic [1:0]  act;
		logic [7:0]  src;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [11:0] length;
		int          reps;
		bit          typed;
		frame_t      want;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
	} req_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [rtl_pkg::ADDR_W-1:0]  paddr = '0;
	logic [rtl_pkg::DATA_W-1:0]  pwdata = '0;
	logic [rtl_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	logic                        req_valid = 1'b0;
	logic                        req_stall;
	logic [1:0]                  action = rtl_pkg::ACT_TICK;
	logic [7:0]                  src_id = '0;
	logic [31:0]                 ack_seq = '0;
	logic [15:0]                 payload_handle = '0;
	logic [11:0]                 payload_length = '0;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	logic [2:0]                  kind;
	logic [31:0]                 frame_seq;
	logic [15:0]                 frame_handle;
	logic [11:0]                 frame_length;
	logic [QCW-1:0]              queue_count;
	logic                        queue_empty;
	logic                        last;

	// link state as the predictor sees it
	logic           tbl_live [QDEPTH];
	logic [31:0]    tbl_seq [QDEPTH];
	logic [15:0]    tbl_handle [QDEPTH];
	logic [11:0]    tbl_len [QDEPTH];
	logic [31:0]    tbl_stamp [QDEPTH];
	logic [31:0]    now_cnt = '0;
	logic [31:0]    seq_next = '0;
	logic [QCW-1:0] pending = '0;
	logic           cfg_run = rtl_pkg::RUN_RESET;
	logic [7:0]     cfg_peer = rtl_pkg::PEER_RESET;
	logic [15:0]    cfg_timeout = rtl_pkg::TIMEOUT_RESET;

	frame_t   frames_due [$];
	req_row_t script [$];
	int       mismatches = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;

	retransmit_table_link DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .action(action), .src_id(src_id),
		.ack_seq(ack_seq), .payload_handle(payload_handle), .payload_length(payload_length),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind), .frame_seq(frame_seq),
		.frame_handle(frame_handle), .frame_length(frame_length),
		.queue_count(queue_count), .queue_empty(queue_empty), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(20 * 3000000);
		$display("tb: failure");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic queue_frame(input logic [2:0] k, input logic [31:0] s, input logic [15:0] h,
			input logic [11:0] l, input logic lst);
		frame_t f;
		f.kind = k;
		f.seq = s;
		f.handle = h;
		f.length = l;
		f.count = pending;
		f.empty = (pending == 0);
		f.last = lst;
		frames_due.push_back(f);
	endtask

	task automatic link_step(input logic [1:0] act, input logic [7:0] src, input logic [31:0] aseq,
			input logic [15:0] handle, input logic [11:0] length);
		int slot;
		int n;
		int j;
		int order [QDEPTH];
		logic [31:0] key;
		slot = -1;
		n = 0;
		case (act)
			rtl_pkg::ACT_SEND: begin
				if (length == 0) begin
					queue_frame(rtl_pkg::K_INVALID, '0, '0, '0, 1'b1);
				end else if (!cfg_run) begin
					queue_frame(rtl_pkg::K_STOP, '0, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < QDEPTH; i++)
						if (slot < 0 && !tbl_live[i])
							slot = i;
					if (slot < 0) begin
						queue_frame(rtl_pkg::K_FULL, '0, '0, '0, 1'b1);
					end else begin
						tbl_live[slot] = 1'b1;
						tbl_seq[slot] = seq_next;
						tbl_handle[slot] = handle;
						tbl_len[slot] = length;
						tbl_stamp[slot] = now_cnt;
						pending++;
						queue_frame(rtl_pkg::K_NEW, seq_next, handle, length, 1'b1);
						seq_next++;
					end
				end
			end
			rtl_pkg::ACT_ACK: begin
				if (src == cfg_peer)
					for (int i = 0; i < QDEPTH; i++)
						if (slot < 0 && tbl_live[i] && tbl_seq[i] == aseq)
							slot = i;
				if (slot >= 0) begin
					tbl_live[slot] = 1'b0;
					pending--;
					queue_frame(rtl_pkg::K_ACK_OK, aseq, tbl_handle[slot], tbl_len[slot], 1'b1);
				end else begin
					queue_frame(rtl_pkg::K_ACK_IGN, aseq, '0, '0, 1'b1);
				end
			end
			rtl_pkg::ACT_TICK: begin
				now_cnt++;
				if (cfg_run)
					for (int i = 0; i < QDEPTH; i++)
						if (tbl_live[i] && (now_cnt - tbl_stamp[i]) >= {16'b0, cfg_timeout}) begin
							// oldest sequence first, counted back from the next one to issue
							key = tbl_seq[i] - seq_next;
							j = n;
							while (j > 0 && (tbl_seq[order[j-1]] - seq_next) > key) begin
								order[j] = order[j-1];
								j--;
							end
							order[j] = i;
							n++;
						end
				for (int k = 0; k < n; k++) begin
					tbl_stamp[order[k]] = now_cnt;
					queue_frame(rtl_pkg::K_RETX, tbl_seq[order[k]], tbl_handle[order[k]],
						tbl_len[order[k]], 1'b0);
				end
				queue_frame(rtl_pkg::K_TICK, '0, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endtask

	function automatic req_row_t req_r(input logic [1:0] act, input logic [7:0] src,
			input logic [31:0] seq, input logic [15:0] h, input logic [11:0] l, input int reps);
		req_row_t r;
		r.what = ROW_REQ;
		r.act = act;
		r.src = src;
		r.seq = seq;
		r.handle = h;
		r.length = l;
		r.reps = reps;
		r.typed = 1'b0;
		r.want = '0;
		r.reg_idx = rtl_pkg::REG_RUN;
		r.reg_val = '0;
		return r;
	endfunction

	function automatic req_row_t typed_r(input logic [1:0] act, input logic [7:0] src,
			input logic [31:0] seq, input logic [15:0] h, input logic [11:0] l,
			input logic [2:0] k, input logic [31:0] fs, input logic [15:0] fh,
			input logic [11:0] fl, input int cnt);
		req_row_t r;
		r = req_r(act, src, seq, h, l, 1);
		r.typed = 1'b1;
		r.want.kind = k;
		r.want.seq = fs;
		r.want.handle = fh;
		r.want.length = fl;
		r.want.count = QCW'(cnt);
		r.want.empty = (cnt == 0);
		r.want.last = 1'b1;
		return r;
	endfunction

	function automatic req_row_t write_r(input logic [1:0] idx, input logic [31:0] val);
		req_row_t r;
		r = req_r(ACT_SPARE, '0, '0, '0, '0, 0);
		r.what = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	task automatic issue(input req_row_t r);
		int n0;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= r.act;
		src_id <= r.src;
		ack_seq <= r.seq;
		payload_handle <= r.handle;
		payload_length <= r.length;
		do @(posedge clk); while (req_stall);
		n0 = frames_due.size();
		link_step(r.act, r.src, r.seq, r.handle, r.length);
		if (r.typed) begin
			while (frames_due.size() > n0)
				void'(frames_due.pop_back());
			frames_due.push_back(r.want);
		end
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rtl_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rtl_pkg::REG_RUN: cfg_run = val[0];
			rtl_pkg::REG_PEER: cfg_peer = val[7:0];
			rtl_pkg::REG_TIMEOUT: cfg_timeout = val[15:0];
			default: ;
		endcase
	endtask

	// each response transaction is checked against the oldest expected frame
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (frames_due.size() == 0) begin
				flag_mismatch("response transaction with nothing expected");
			end else begin
				want = frames_due.pop_front();
				cmp_field("kind", 32'(kind), 32'(want.kind));
				cmp_field("frame_seq", frame_seq, want.seq);
				cmp_field("frame_handle", 32'(frame_handle), 32'(want.handle));
				cmp_field("frame_length", 32'(frame_length), 32'(want.length));
				cmp_field("queue_count", 32'(queue_count), 32'(want.count));
				cmp_field("queue_empty", 32'(queue_empty), 32'(want.empty));
				cmp_field("last", 32'(last), 32'(want.last));
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		req_row_t r;
		int made;
		int roll;
		int start;
		int j;
		for (int i = 0; i < QDEPTH; i++)
			tbl_live[i] = 1'b0;

		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'hffff, 12'h000,
			rtl_pkg::K_INVALID, 32'h0, 16'h0, 12'h0, 0));
		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h0000, 12'hfff,
			rtl_pkg::K_NEW, 32'h0, 16'h0000, 12'hfff, 1));
		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'hffff, 12'h001,
			rtl_pkg::K_NEW, 32'h1, 16'hffff, 12'h001, 2));
		script.push_back(typed_r(rtl_pkg::ACT_ACK, 8'h01, 32'h0, 16'h0, 12'h0,
			rtl_pkg::K_ACK_IGN, 32'h0, 16'h0, 12'h0, 2));
		script.push_back(typed_r(rtl_pkg::ACT_ACK, 8'h00, 32'hffffffff, 16'h0, 12'h0,
			rtl_pkg::K_ACK_IGN, 32'hffffffff, 16'h0, 12'h0, 2));
		script.push_back(typed_r(rtl_pkg::ACT_ACK, 8'h00, 32'h0, 16'h0, 12'h0,
			rtl_pkg::K_ACK_OK, 32'h0, 16'h0000, 12'hfff, 1));
		script.push_back(typed_r(rtl_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 12'h0,
			rtl_pkg::K_TICK, 32'h0, 16'h0, 12'h0, 1));
		script.push_back(req_r(ACT_SPARE, 8'hff, 32'hffffffff, 16'hffff, 12'hfff, 1));
		script.push_back(write_r(rtl_pkg::REG_TIMEOUT, 32'd1));
		script.push_back(write_r(rtl_pkg::REG_PEER, 32'hff));
		script.push_back(typed_r(rtl_pkg::ACT_ACK, 8'hff, 32'h1, 16'h0, 12'h0,
			rtl_pkg::K_ACK_OK, 32'h1, 16'hffff, 12'h001, 0));
		script.push_back(typed_r(rtl_pkg::ACT_ACK, 8'h00, 32'h1, 16'h0, 12'h0,
			rtl_pkg::K_ACK_IGN, 32'h1, 16'h0, 12'h0, 0));
		script.push_back(req_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h5a5a, 12'h0a5, QDEPTH));
		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h1234, 12'h005,
			rtl_pkg::K_FULL, 32'h0, 16'h0, 12'h0, QDEPTH));
		script.push_back(req_r(rtl_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 12'h0, 1));
		script.push_back(write_r(rtl_pkg::REG_RUN, 32'd0));
		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h0001, 12'h001,
			rtl_pkg::K_STOP, 32'h0, 16'h0, 12'h0, QDEPTH));
		script.push_back(typed_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h0001, 12'h000,
			rtl_pkg::K_INVALID, 32'h0, 16'h0, 12'h0, QDEPTH));
		script.push_back(typed_r(rtl_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 12'h0,
			rtl_pkg::K_TICK, 32'h0, 16'h0, 12'h0, QDEPTH));
		script.push_back(req_r(rtl_pkg::ACT_ACK, 8'hff, 32'd9, 16'h0, 12'h0, 1));
		script.push_back(write_r(rtl_pkg::REG_RUN, 32'd1));
		script.push_back(write_r(rtl_pkg::REG_TIMEOUT, 32'd0));
		script.push_back(req_r(rtl_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 12'h0, 1));
		script.push_back(write_r(rtl_pkg::REG_TIMEOUT, 32'hffff));
		script.push_back(req_r(rtl_pkg::ACT_TICK, 8'h00, 32'h0, 16'h0, 12'h0, 1));
		script.push_back(req_r(rtl_pkg::ACT_SEND, 8'h00, 32'h0, 16'h0000, 12'h001, 1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[n]) begin
			if (script[n].what == ROW_WRITE) begin
				settle();
				write_reg(script[n].reg_idx, script[n].reg_val);
			end else begin
				repeat (script[n].reps) issue(script[n]);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 47; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 47; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			write_reg(rtl_pkg::REG_RUN, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
			write_reg(rtl_pkg::REG_PEER, $urandom_range(255));
			case ($urandom_range(6))
				0: write_reg(rtl_pkg::REG_TIMEOUT, 32'd0);
				1: write_reg(rtl_pkg::REG_TIMEOUT, 32'd1);
				2: write_reg(rtl_pkg::REG_TIMEOUT, 32'd2);
				3: write_reg(rtl_pkg::REG_TIMEOUT, 32'd3);
				4: write_reg(rtl_pkg::REG_TIMEOUT, $urandom_range(12, 4));
				5: write_reg(rtl_pkg::REG_TIMEOUT, 32'hffff);
				default: write_reg(rtl_pkg::REG_TIMEOUT, $urandom_range(65535, 1));
			endcase
			made = 0;
			while (made < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				r = req_r(rtl_pkg::ACT_TICK, 8'($urandom_range(255)), $urandom,
					16'($urandom_range(65535)), 12'($urandom_range(4095)), 1);
				if (roll < 40) begin
					r.act = rtl_pkg::ACT_SEND;
					if ($urandom_range(19) == 0)
						r.length = '0;
				end else if (roll < 70) begin
					r.act = rtl_pkg::ACT_ACK;
					if ($urandom_range(3) != 0) begin
						// mostly a real ack from the peer for a frame still in flight
						r.src = cfg_peer;
						start = $urandom_range(QDEPTH - 1);
						for (int k = 0; k < QDEPTH; k++) begin
							j = (start + k) % QDEPTH;
							if (tbl_live[j])
								r.seq = tbl_seq[j];
						end
					end
				end else if (roll >= 95) begin
					r.act = ACT_SPARE;
				end
				issue(r);
				if (r.act != ACT_SPARE)
					made++;
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/rtl_pkg.sv
src/rtl_cell.sv
src/rtl_ctrl.sv
src/retransmit_table_link.sv
verif/retransmit_table_link_test.sv
